FILE: hw/rtl/lbd_pkg.sv
// Shared types and constants for the 4-connected label boundary detector.
package lbd_pkg;

  // Row counter, result column, configuration data and raster width field widths
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned OUT_COL_W = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned RWID_W   = 13;

  // Configuration register indexes
  typedef enum logic {
    CFG_RASTER_WIDTH  = 1'b0,
    CFG_RASTER_HEIGHT = 1'b1
  } lbd_cfg_idx_e;

  // Per-pixel flags handed from the front stage to the result stage
  typedef struct packed {
    logic left_diff;  // left neighbor differs (column > 0)
    logic edge_px;    // pixel sits on the raster edge
    logic has_up;     // row > 0, a pixel above exists
    logic last_row;   // pixel is in the final row
    logic col_last;   // pixel is in the final column
  } lbd_flags_t;

endpackage

FILE: hw/rtl/lbd_ram.sv
// Simple dual-port RAM: one write port, one registered read port (read-first).
module lbd_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lbd_front.sv
// Front stage: configuration registers, raster position tracking and left-neighbor compare.
module lbd_front import lbd_pkg::*; #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned CAT_BITS = 32,
  parameter int unsigned CW       = $clog2(MAX_COLS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  // incoming request
  input  logic                acc_i,
  input  logic [CAT_BITS-1:0] cat_i,
  input  logic                frame_start_i,
  // resolved pixel
  output logic [CW-1:0]       col_o,
  output logic [ROW_W-1:0]    row_o,
  output lbd_flags_t          flags_o
);

  localparam int unsigned W_RST = (MAX_COLS < 4096) ? MAX_COLS : 4096;
  localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);

  logic [CW-1:0]       w_last_q;
  logic [ROW_W-1:0]    h_last_q;
  logic [CW-1:0]       col_pos_q, col_pos_d;
  logic [ROW_W-1:0]    row_pos_q, row_pos_d;
  logic [CAT_BITS-1:0] left_q;

  logic [RWID_W-1:0]   w_raw;
  logic [ROW_W-1:0]    h_raw;
  logic [CW-1:0]       w_last_new;
  logic [ROW_W-1:0]    h_last_new;
  logic [CW-1:0]       c0, c;
  logic [ROW_W-1:0]    r0, r1, r;

  // Clamp written width/height and keep them as last-index values
  always_comb begin
    w_raw = cfg_data_i[RWID_W-1:0];
    h_raw = cfg_data_i[ROW_W-1:0];
    if (w_raw == '0) begin
      w_last_new = '0;
    end else if (32'(w_raw) > MAX_COLS) begin
      w_last_new = CW'(MAX_COLS - 1);
    end else begin
      w_last_new = CW'(w_raw - RWID_W'(1));
    end
    h_last_new = (h_raw == '0) ? '0 : h_raw - ROW_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= W_LAST_RST;
      h_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lbd_cfg_idx_e'(cfg_idx_i))
        CFG_RASTER_WIDTH:  w_last_q <= w_last_new;
        CFG_RASTER_HEIGHT: h_last_q <= h_last_new;
        default: ;
      endcase
    end
  end

  // Resolve the position of this pixel (frame start, shrunken raster)
  always_comb begin
    c0 = frame_start_i ? '0 : col_pos_q;
    r0 = frame_start_i ? '0 : row_pos_q;
    if (c0 > w_last_q) begin
      c  = '0;
      r1 = r0 + ROW_W'(1);
    end else begin
      c  = c0;
      r1 = r0;
    end
    r = (r1 > h_last_q) ? '0 : r1;
  end

  // Advance position past this pixel, wrapping at end of row and frame
  always_comb begin
    if (c == w_last_q) begin
      col_pos_d = '0;
      row_pos_d = (r == h_last_q) ? '0 : r + ROW_W'(1);
    end else begin
      col_pos_d = c + CW'(1);
      row_pos_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      left_q    <= '0;
    end else if (acc_i) begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
      left_q    <= cat_i;
    end
  end

  // Pixel flags
  always_comb begin
    flags_o.left_diff = (c != '0) && (left_q != cat_i);
    flags_o.edge_px   = (r == '0) || (c == '0) || (c == w_last_q) || (r == h_last_q);
    flags_o.has_up    = (r != '0);
    flags_o.last_row  = (r == h_last_q);
    flags_o.col_last  = (c == w_last_q);
  end

  assign col_o = c;
  assign row_o = r;

endmodule

FILE: hw/rtl/lbd_back.sv
// Result stage: up-neighbor compare, mark merging and write-back, result sequencing.
module lbd_back import lbd_pkg::*; #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned CAT_BITS = 32,
  parameter int unsigned CW       = $clog2(MAX_COLS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // new pixel from the front stage
  input  logic                 acc_i,
  input  logic [CW-1:0]        col_i,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [CAT_BITS-1:0]  cat_i,
  input  lbd_flags_t           flags_i,
  // RAM read data for the held pixel
  input  logic [CAT_BITS-1:0]  up_cat_i,
  input  logic                 up_mark_i,
  // mark write-back
  output logic                 mark_we_o,
  output logic [CW-1:0]        mark_waddr_o,
  output logic                 mark_wdata_o,
  // stage held and cannot take a new pixel
  output logic                 busy_o,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 boundary_o,
  output logic [ROW_W-1:0]     out_row_o,
  output logic [OUT_COL_W-1:0] out_col_o,
  output logic                 frame_last_o
);

  // held pixel
  logic                s1_valid_q;
  logic [CW-1:0]       s1_col_q;
  logic [ROW_W-1:0]    s1_row_q;
  logic [CAT_BITS-1:0] s1_cat_q;
  lbd_flags_t          s1_flags_q;
  logic                sub_q;
  // mark written in the same cycle as this pixel's read
  logic                byp_q;
  logic                byp_mark_q;
  // partial mark of the previous pixel, not yet written
  logic                pend_valid_q;
  logic [CW-1:0]       pend_col_q;
  logic                pend_mark_q;
  // output register
  logic                out_valid_q;
  logic                boundary_q;
  logic [ROW_W-1:0]    out_row_q;
  logic [OUT_COL_W-1:0] out_col_q;
  logic                frame_last_q;

  logic up_diff, mark_above, res_above, partial;
  logic need_out, more_after, out_free, emit, consume, emit_above;

  // Mark of the pixel above, with bypass of writes the RAM read missed
  always_comb begin
    up_diff = (s1_cat_q != up_cat_i);
    if (pend_valid_q && (pend_col_q == s1_col_q)) begin
      mark_above = pend_mark_q | s1_flags_q.left_diff;
    end else if (byp_q) begin
      mark_above = byp_mark_q;
    end else begin
      mark_above = up_mark_i;
    end
    res_above = mark_above | up_diff;
    partial   = s1_flags_q.edge_px | s1_flags_q.left_diff |
                (s1_flags_q.has_up & up_diff);
  end

  // Result sequencing: above-pixel result first, own result on the last row
  always_comb begin
    need_out   = s1_flags_q.has_up | s1_flags_q.last_row;
    more_after = s1_flags_q.has_up & s1_flags_q.last_row & !sub_q;
    emit_above = s1_flags_q.has_up & !sub_q;
    out_free   = !out_valid_q || !out_stall_i;
    emit       = s1_valid_q && need_out && out_free;
    consume    = s1_valid_q && (!need_out || (out_free && !more_after));
  end

  assign busy_o = s1_valid_q && !consume;

  // Final mark of the previous pixel goes to RAM once this pixel retires
  assign mark_we_o    = consume && pend_valid_q;
  assign mark_waddr_o = pend_col_q;
  assign mark_wdata_o = pend_mark_q | s1_flags_q.left_diff;

  // Held pixel control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      sub_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (consume) begin
        s1_valid_q <= 1'b0;
      end
      if (consume) begin
        sub_q        <= 1'b0;
        pend_valid_q <= 1'b1;
      end else if (emit) begin
        sub_q <= 1'b1;
      end
    end
  end

  // Held pixel payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_col_q   <= col_i;
      s1_row_q   <= row_i;
      s1_cat_q   <= cat_i;
      s1_flags_q <= flags_i;
      byp_q      <= mark_we_o && (mark_waddr_o == col_i);
      byp_mark_q <= mark_wdata_o;
    end
    if (consume) begin
      pend_col_q  <= s1_col_q;
      pend_mark_q <= partial;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (emit_above) begin
        boundary_q   <= res_above;
        out_row_q    <= s1_row_q - ROW_W'(1);
        frame_last_q <= 1'b0;
      end else begin
        boundary_q   <= 1'b1;
        out_row_q    <= s1_row_q;
        frame_last_q <= s1_flags_q.col_last;
      end
      out_col_q <= OUT_COL_W'(s1_col_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign boundary_o   = boundary_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = frame_last_q;

endmodule

FILE: hw/rtl/label_boundary_detect_4conn.sv
// Top level of the 4-connected label boundary detector.
//
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid_i/in_stall_o  category_i, frame_start_i
//  out      output     out_valid_o/out_stall_i boundary_o, out_row_o, out_col_o, frame_last_o
//  cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// One pixel per clock while in_stall_o is low; a pixel's reads of the line and mark RAMs are registered.
// Last-row pixels below row 0 give two results and hold the result stage until both are sent.
// Results are for the pixel one row above, so they trail the input by one row; the last row also gives its own results.
// Reset clears position, left pixel and handshake state and restores the default raster size; the RAMs are not cleared.
// A stalled output holds its result and backs up into in_stall_o.
module label_boundary_detect_4conn import lbd_pkg::*; #(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned CAT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          category_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 boundary_o,
  output logic [ROW_W-1:0]     out_row_o,
  output logic [OUT_COL_W-1:0] out_col_o,
  output logic                 frame_last_o
);

  localparam int unsigned CW = $clog2(MAX_COLS);

  logic                acc;
  logic                busy;
  logic [CAT_BITS-1:0] cat;
  logic [CW-1:0]       col;
  logic [ROW_W-1:0]    row;
  lbd_flags_t          flags;
  logic [CAT_BITS-1:0] up_cat;
  logic                up_mark;
  logic                mark_we;
  logic [CW-1:0]       mark_waddr;
  logic                mark_wdata;

  assign cat        = CAT_BITS'(category_i);
  assign in_stall_o = busy;
  assign acc        = in_valid_i && !busy;

  lbd_front #(
    .MAX_COLS (MAX_COLS),
    .CAT_BITS (CAT_BITS),
    .CW       (CW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .acc_i         (acc),
    .cat_i         (cat),
    .frame_start_i (frame_start_i),
    .col_o         (col),
    .row_o         (row),
    .flags_o       (flags)
  );

  // Previous row's categories
  lbd_ram #(
    .DW    (CAT_BITS),
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (col),
    .wdata_i (cat),
    .re_i    (acc),
    .raddr_i (col),
    .rdata_o (up_cat)
  );

  // Previous row's boundary marks
  lbd_ram #(
    .DW    (1),
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (acc),
    .raddr_i (col),
    .rdata_o (up_mark)
  );

  lbd_back #(
    .MAX_COLS (MAX_COLS),
    .CAT_BITS (CAT_BITS),
    .CW       (CW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .col_i        (col),
    .row_i        (row),
    .cat_i        (cat),
    .flags_i      (flags),
    .up_cat_i     (up_cat),
    .up_mark_i    (up_mark),
    .mark_we_o    (mark_we),
    .mark_waddr_o (mark_waddr),
    .mark_wdata_o (mark_wdata),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .boundary_o   (boundary_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

endmodule
